### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the annunciator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/aan_pkg.sv
// ----------------------------------------------------------------------------
// aan_pkg
// Shared types and constants for the alarm annunciator with snooze.
// ----------------------------------------------------------------------------
package aan_pkg;

  localparam int TIMER_WIDTH_DEF = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZER_EN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNOOZE_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_WAIT = 2'd2;

  localparam logic        BUZZER_EN_RST    = 1'b1;
  localparam logic [15:0] STARTUP_WAIT_RST = 16'd30000;

  // Snooze limit is held pre-scaled to ticks: minutes * 60000 fits 24 bits
  localparam int          SNOOZE_LIMIT_W   = 24;
  localparam int          TICKS_PER_MINUTE = 60000;
  localparam logic [SNOOZE_LIMIT_W-1:0] SNOOZE_LIMIT_RST =
    SNOOZE_LIMIT_W'(5 * TICKS_PER_MINUTE);

  // Item kinds
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_MUTE = 1'b1;

  // Alarm codes
  localparam logic [3:0] CODE_NONE     = 4'd0;
  localparam logic [3:0] CODE_FIRE     = 4'd1;
  localparam logic [3:0] CODE_SENSOR   = 4'd2;
  localparam logic [3:0] CODE_HIGH_TMP = 4'd3;
  localparam logic [3:0] CODE_FAN1     = 4'd4;
  localparam logic [3:0] CODE_FAN2     = 4'd5;
  localparam logic [3:0] CODE_FAN3     = 4'd6;
  localparam logic [3:0] CODE_FAN4     = 4'd7;
  localparam logic [3:0] CODE_LOW_TMP  = 4'd8;

  typedef struct packed {
    logic       action;
    logic       fire_active;
    logic       sensor_fault;
    logic       temp_critical_high;
    logic       temp_below_low;
    logic [3:0] fan_faults;
  } item_t;

  typedef struct packed {
    logic       buzzer_on;
    logic [3:0] alarm_code;
    logic       in_alarm;
    logic       alarm_logged;
    logic       alarm_cleared;
  } result_t;

endpackage

### hdl/aan_intf.sv
// ----------------------------------------------------------------------------
// aan_in_if / aan_out_if
// Valid/ready channels carrying condition beats in and status beats out.
// ----------------------------------------------------------------------------
interface aan_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic       fire_active;
  logic       sensor_fault;
  logic       temp_critical_high;
  logic       temp_below_low;
  logic [3:0] fan_faults;

  modport source (output valid, action, fire_active, sensor_fault,
                  temp_critical_high, temp_below_low, fan_faults,
                  input ready);
  modport sink   (input valid, action, fire_active, sensor_fault,
                  temp_critical_high, temp_below_low, fan_faults,
                  output ready);
endinterface

interface aan_out_if;
  logic       valid;
  logic       ready;
  logic       buzzer_on;
  logic [3:0] alarm_code;
  logic       in_alarm;
  logic       alarm_logged;
  logic       alarm_cleared;

  modport source (output valid, buzzer_on, alarm_code, in_alarm,
                  alarm_logged, alarm_cleared, input ready);
  modport sink   (input valid, buzzer_on, alarm_code, in_alarm,
                  alarm_logged, alarm_cleared, output ready);
endinterface

### hdl/alarm_annunciator_with_snooze_unit.sv
// ----------------------------------------------------------------------------
// alarm_annunciator_with_snooze_unit
// Alarm annunciator: priority-encodes fault beats, runs the start-up wait,
// alarm and snooze modes, and drives buzzer and alarm status beats.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake         Beat contents
//  in_ch    in   valid/ready       action, fault conditions, fan_faults
//  out_ch   out  valid/ready       buzzer_on, alarm_code, in_alarm, pulses
//  cfg_*    in   cfg_we only       cfg_idx, cfg_data (no read-back)
//
//  One beat per cycle sustained while out_ch takes beats; each beat yields
//  exactly one result beat. A beat passes the input register, then the
//  mode logic into the result register; state updates as it moves there.
//  Synchronous active-low reset: wait mode, code none, timer and config to
//  their reset values. A stalled out_ch holds both stages; in_ch.ready drops
//  only when both registers are full and out_ch is not taking.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alarm_annunciator_with_snooze_unit #(
  parameter int TIMER_WIDTH = aan_pkg::TIMER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  aan_in_if.sink                         in_ch,
  aan_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [aan_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [aan_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic                                buzzer_en_r;
  logic [15:0]                         startup_wait_r;
  logic [aan_pkg::SNOOZE_LIMIT_W-1:0]  snooze_limit_r;

  // pipeline
  aan_pkg::item_t   in_item, item_r;
  aan_pkg::result_t res, res_r;
  logic             s1_valid_r, out_valid_r;
  logic             adv, in_acc;
  logic [3:0]       code;

  always_comb begin
    in_item.action             = in_ch.action;
    in_item.fire_active        = in_ch.fire_active;
    in_item.sensor_fault       = in_ch.sensor_fault;
    in_item.temp_critical_high = in_ch.temp_critical_high;
    in_item.temp_below_low     = in_ch.temp_below_low;
    in_item.fan_faults         = in_ch.fan_faults;
  end

  // Snooze length is scaled to ticks on write, so the snooze compare sees
  // a ready-made limit and no multiplier sits in the beat path.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buzzer_en_r    <= aan_pkg::BUZZER_EN_RST;
      startup_wait_r <= aan_pkg::STARTUP_WAIT_RST;
      snooze_limit_r <= aan_pkg::SNOOZE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        aan_pkg::CFG_BUZZER_EN:    buzzer_en_r    <= cfg_data[0];
        aan_pkg::CFG_SNOOZE_MIN:   snooze_limit_r <=
          aan_pkg::SNOOZE_LIMIT_W'(cfg_data[7:0]) *
          aan_pkg::SNOOZE_LIMIT_W'(aan_pkg::TICKS_PER_MINUTE);
        aan_pkg::CFG_STARTUP_WAIT: startup_wait_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: a beat leaves the input register whenever the result
  // register is empty or being drained this cycle.
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (adv)              out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) item_r <= in_item;
    if (adv)    res_r  <= res;
  end

  aan_prio u_prio (
    .item (item_r),
    .code (code)
  );

  aan_ctrl #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv),
    .item         (item_r),
    .code         (code),
    .buzzer_en    (buzzer_en_r),
    .startup_wait (startup_wait_r),
    .snooze_limit (snooze_limit_r),
    .res          (res)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.buzzer_on     = res_r.buzzer_on;
  assign out_ch.alarm_code    = res_r.alarm_code;
  assign out_ch.in_alarm      = res_r.in_alarm;
  assign out_ch.alarm_logged  = res_r.alarm_logged;
  assign out_ch.alarm_cleared = res_r.alarm_cleared;

  // buzzer only sounds from the alarm state proper
  `ASSERT_IMPL(a_buzzer_in_alarm, clk, rst_n,
               out_valid_r && res_r.buzzer_on, res_r.in_alarm)
  `ASSERT_IMPL(a_pulses_exclusive, clk, rst_n,
               out_valid_r && res_r.alarm_logged,
               !res_r.alarm_cleared && res_r.alarm_code != aan_pkg::CODE_NONE)
  `ASSERT_NEXT(a_stall_holds_stage, clk, rst_n,
               s1_valid_r && out_valid_r && !out_ch.ready,
               s1_valid_r && $stable(item_r))

endmodule

### hdl/aan_prio.sv
// ----------------------------------------------------------------------------
// aan_prio
// Priority encoder: highest active fault condition to an alarm code.
// ----------------------------------------------------------------------------
module aan_prio (
  input  aan_pkg::item_t   item,
  output logic [3:0]       code
);

  always_comb begin
    if (item.fire_active)             code = aan_pkg::CODE_FIRE;
    else if (item.sensor_fault)       code = aan_pkg::CODE_SENSOR;
    else if (item.temp_critical_high) code = aan_pkg::CODE_HIGH_TMP;
    else if (item.fan_faults[0])      code = aan_pkg::CODE_FAN1;
    else if (item.fan_faults[1])      code = aan_pkg::CODE_FAN2;
    else if (item.fan_faults[2])      code = aan_pkg::CODE_FAN3;
    else if (item.fan_faults[3])      code = aan_pkg::CODE_FAN4;
    else if (item.temp_below_low)     code = aan_pkg::CODE_LOW_TMP;
    else                              code = aan_pkg::CODE_NONE;
  end

endmodule

### hdl/aan_ctrl.sv
// ----------------------------------------------------------------------------
// aan_ctrl
// Mode state machine, shown code and tick timer; forms one status result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aan_ctrl #(
  parameter int TIMER_WIDTH = aan_pkg::TIMER_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  aan_pkg::item_t                      item,
  input  logic [3:0]                          code,
  input  logic                                buzzer_en,
  input  logic [15:0]                         startup_wait,
  input  logic [aan_pkg::SNOOZE_LIMIT_W-1:0]  snooze_limit,
  output aan_pkg::result_t                    res
);

  localparam int CMP_W = (TIMER_WIDTH > aan_pkg::SNOOZE_LIMIT_W) ?
                         TIMER_WIDTH : aan_pkg::SNOOZE_LIMIT_W;

  typedef enum logic [1:0] {
    MODE_WAIT,
    MODE_IDLE,
    MODE_ALARM,
    MODE_SNOOZE
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [3:0]             shown_r, shown_nxt;
  logic [TIMER_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [TIMER_WIDTH-1:0] elapsed_inc;
  logic                   logged, cleared, sounds;

  // saturating bump
  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + TIMER_WIDTH'(1);

  always_comb begin
    mode_nxt    = mode_r;
    shown_nxt   = shown_r;
    elapsed_nxt = elapsed_r;
    logged      = 1'b0;
    cleared     = 1'b0;
    if (item.action == aan_pkg::ACT_MUTE) begin
      if (mode_r == MODE_ALARM || mode_r == MODE_SNOOZE) begin
        mode_nxt    = MODE_SNOOZE;
        elapsed_nxt = '0;
      end
    end else begin
      case (mode_r)
        MODE_WAIT: begin
          if (elapsed_inc >= TIMER_WIDTH'(startup_wait)) begin
            mode_nxt    = MODE_IDLE;
            elapsed_nxt = '0;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
        MODE_IDLE: begin
          if (code != aan_pkg::CODE_NONE) begin
            shown_nxt = code;
            logged    = 1'b1;
            mode_nxt  = MODE_ALARM;
          end
        end
        MODE_ALARM: begin
          if (code == aan_pkg::CODE_NONE) begin
            shown_nxt = aan_pkg::CODE_NONE;
            cleared   = 1'b1;
            mode_nxt  = MODE_IDLE;
          end else if (code != shown_r) begin
            shown_nxt = code;
            logged    = 1'b1;
          end
        end
        MODE_SNOOZE: begin
          elapsed_nxt = elapsed_inc;
          if (code == aan_pkg::CODE_NONE) begin
            shown_nxt = aan_pkg::CODE_NONE;
            cleared   = 1'b1;
            mode_nxt  = MODE_IDLE;
          end else if (code != shown_r) begin
            shown_nxt = code;
            logged    = 1'b1;
            mode_nxt  = MODE_ALARM;
          end else if (CMP_W'(elapsed_inc) > CMP_W'(snooze_limit)) begin
            mode_nxt  = MODE_ALARM;
          end
        end
        default: mode_nxt = MODE_WAIT;
      endcase
    end
  end

  // low temperature shows but stays silent
  assign sounds = (shown_nxt != aan_pkg::CODE_NONE) &&
                  (shown_nxt != aan_pkg::CODE_LOW_TMP);

  always_comb begin
    res.buzzer_on     = sounds && buzzer_en && (mode_nxt != MODE_SNOOZE);
    res.alarm_code    = shown_nxt;
    res.in_alarm      = (mode_nxt == MODE_ALARM) || (mode_nxt == MODE_SNOOZE);
    res.alarm_logged  = logged;
    res.alarm_cleared = cleared;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_WAIT;
      shown_r   <= aan_pkg::CODE_NONE;
      elapsed_r <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      shown_r   <= shown_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  `ASSERT_IMPL(a_quiet_modes_no_code, clk, rst_n,
               mode_r == MODE_WAIT || mode_r == MODE_IDLE,
               shown_r == aan_pkg::CODE_NONE)
  `ASSERT_IMPL(a_alarm_modes_have_code, clk, rst_n,
               mode_r == MODE_ALARM || mode_r == MODE_SNOOZE,
               shown_r != aan_pkg::CODE_NONE)
  `ASSERT_NEXT(a_mute_snoozes, clk, rst_n,
               step && item.action == aan_pkg::ACT_MUTE && res.in_alarm,
               mode_r == MODE_SNOOZE && elapsed_r == '0)

endmodule
